@@ sv/crx_pkg.sv @@
// Package for the COBS frame receiver: event and status structs, result word,
// register indexes and the constants of the decoder and checksum.
// Used by crx_decoder, crx_checker and cobs_frame_receiver.
`default_nettype none

package crx_pkg;

    localparam logic [7:0] DELIM_BYTE = 8'h00;
    localparam logic [7:0] FULL_CODE  = 8'hFF;
    localparam logic [8:0] MOD_BASE   = 9'd255;
    localparam logic [8:0] LEN_SAT    = 9'd511;

    // Configuration register indexes.
    localparam logic [7:0] CFG_OWN_ID      = 8'd0;
    localparam logic [7:0] CFG_ID_POSITION = 8'd1;

    // Result kind codes.
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // What one accepted word does to the frame.
    typedef struct packed {
        logic       take;      // a decoded byte comes out
        logic [7:0] value;     // the decoded byte
        logic       close;     // delimiter that ends a frame: status comes out
        logic       overrun;   // the closing frame was too long
        logic       code_err;  // a group still expected data at the delimiter
        logic       clear;     // any delimiter: frame state starts over
    } crx_event_t;

    typedef struct packed {
        logic [8:0] frame_length;
        logic       checksum_ok;
        logic       address_ok;
        logic       too_short;
    } crx_status_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [8:0] frame_length;
        logic       checksum_ok;
        logic       address_ok;
        logic       too_long;
        logic       coding_error;
        logic       too_short;
        logic       frame_good;
    } crx_result_t;

endpackage

`default_nettype wire

@@ sv/crx_decoder.sv @@
// COBS decoding state of the frame receiver: hunting, encoded byte count,
// group counter, pending zero and the too-long flag. Depends on crx_pkg.
`default_nettype none

module crx_decoder #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [7:0]         rx_byte,
    output crx_pkg::crx_event_t     ev
);
    import crx_pkg::*;

    localparam int CW = $clog2(MAX_FRAME_BYTES);
    localparam logic [CW-1:0] ENC_LIMIT = CW'(MAX_FRAME_BYTES - 1);

    logic          hunting_reg, hunting_next;
    logic [CW-1:0] enc_count_reg, enc_count_next;
    logic [7:0]    group_left_reg, group_left_next;
    logic          zero_pending_reg, zero_pending_next;
    logic          too_long_reg, too_long_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunting_reg      <= 1'b1;
            enc_count_reg    <= '0;
            group_left_reg   <= '0;
            zero_pending_reg <= 1'b0;
            too_long_reg     <= 1'b0;
        end
        else
        begin
            hunting_reg      <= hunting_next;
            enc_count_reg    <= enc_count_next;
            group_left_reg   <= group_left_next;
            zero_pending_reg <= zero_pending_next;
            too_long_reg     <= too_long_next;
        end
    end

    always_comb
    begin
        hunting_next      = hunting_reg;
        enc_count_next    = enc_count_reg;
        group_left_next   = group_left_reg;
        zero_pending_next = zero_pending_reg;
        too_long_next     = too_long_reg;
        ev                = '0;
        if (accept)
        begin
            priority if (rx_byte == DELIM_BYTE)
            begin
                ev.clear = 1'b1;
                if (!hunting_reg)
                begin
                    ev.close    = 1'b1;
                    ev.overrun  = too_long_reg;
                    ev.code_err = (group_left_reg != 8'd0);
                end
                hunting_next      = 1'b0;
                enc_count_next    = '0;
                group_left_next   = '0;
                zero_pending_next = 1'b0;
                too_long_next     = 1'b0;
            end
            else if (hunting_reg || too_long_reg)
            begin
                // Bytes before the first delimiter or after an overrun are dropped.
            end
            else if (enc_count_reg >= ENC_LIMIT)
            begin
                too_long_next = 1'b1;
            end
            else
            begin
                enc_count_next = enc_count_reg + 1'b1;
                if (group_left_reg != 8'd0)
                begin
                    group_left_next = group_left_reg - 8'd1;
                    ev.take         = 1'b1;
                    ev.value        = rx_byte;
                end
                else
                begin
                    // Code byte: the zero implied by the previous group comes out now.
                    group_left_next   = rx_byte - 8'd1;
                    zero_pending_next = (rx_byte != FULL_CODE);
                    ev.take           = zero_pending_reg;
                    ev.value          = DELIM_BYTE;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/crx_checker.sv @@
// Frame checks of the receiver: decoded byte count, Fletcher-16 sums mod 255,
// two-byte tail delay line and address match. Depends on crx_pkg.
`default_nettype none

module crx_checker #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire crx_pkg::crx_event_t ev,
    input  wire logic [7:0]          own_id,
    input  wire logic [7:0]          id_position,
    output crx_pkg::crx_status_t     status
);
    import crx_pkg::*;

    localparam int CW = $clog2(MAX_FRAME_BYTES);
    localparam int PW = (CW > 8) ? CW : 8;
    localparam int LW = (CW > 9) ? CW : 9;

    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    sum_low_reg, sum_low_next;
    logic [7:0]    sum_high_reg, sum_high_next;
    logic [7:0]    tail0_reg, tail0_next;
    logic [7:0]    tail1_reg, tail1_next;
    logic          addr_ok_reg, addr_ok_next;

    logic [PW-1:0] count_wide;
    logic [PW-1:0] pos_wide;
    logic [LW-1:0] count_len;
    logic [8:0]    low_sum, low_mod, high_sum, high_mod;
    logic          short_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sum_low_reg  <= '0;
            sum_high_reg <= '0;
            tail0_reg    <= '0;
            tail1_reg    <= '0;
            addr_ok_reg  <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            sum_low_reg  <= sum_low_next;
            sum_high_reg <= sum_high_next;
            tail0_reg    <= tail0_next;
            tail1_reg    <= tail1_next;
            addr_ok_reg  <= addr_ok_next;
        end
    end

    assign count_wide = PW'(count_reg);
    assign pos_wide   = PW'(id_position);

    // The byte leaving the tail line is folded into both sums, each mod 255.
    assign low_sum  = {1'b0, sum_low_reg} + {1'b0, tail0_reg};
    assign low_mod  = (low_sum >= MOD_BASE) ? (low_sum - MOD_BASE) : low_sum;
    assign high_sum = {1'b0, sum_high_reg} + {1'b0, low_mod[7:0]};
    assign high_mod = (high_sum >= MOD_BASE) ? (high_sum - MOD_BASE) : high_sum;

    always_comb
    begin
        count_next    = count_reg;
        sum_low_next  = sum_low_reg;
        sum_high_next = sum_high_reg;
        tail0_next    = tail0_reg;
        tail1_next    = tail1_reg;
        addr_ok_next  = addr_ok_reg;
        priority if (ev.clear)
        begin
            count_next    = '0;
            sum_low_next  = '0;
            sum_high_next = '0;
            tail0_next    = '0;
            tail1_next    = '0;
            addr_ok_next  = 1'b0;
        end
        else if (ev.take)
        begin
            if (count_wide == pos_wide)
            begin
                addr_ok_next = (ev.value == own_id);
            end
            if (count_reg >= CW'(2))
            begin
                sum_low_next  = low_mod[7:0];
                sum_high_next = high_mod[7:0];
            end
            tail0_next = tail1_reg;
            tail1_next = ev.value;
            count_next = count_reg + 1'b1;
        end
        else
        begin
            // No decoded byte this cycle: the frame state holds.
        end
    end

    assign count_len   = LW'(count_reg);
    assign short_frame = (count_reg < CW'(2));

    always_comb
    begin
        status.frame_length = (count_len > LW'(LEN_SAT)) ? LEN_SAT : count_len[8:0];
        status.too_short    = short_frame;
        status.address_ok   = addr_ok_reg;
        status.checksum_ok  = !short_frame &&
                              ({tail0_reg, tail1_reg} == {sum_high_reg, sum_low_reg});
    end

endmodule

`default_nettype wire

@@ sv/cobs_frame_receiver.sv @@
// Each result is on the outputs in the cycle after the byte that causes it.
// Throughput: one received byte per cycle; the output register is refilled in
// the cycle it is taken, so input stalls only while a result waits unread.
// Reset: hunts for the first delimiter, clears all frame state, own_id and
// id_position read 0, no result pending. Configuration writes are always accepted.
`default_nettype none

module cobs_frame_receiver #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            kind,
    output logic [7:0]      data_byte,
    output logic [8:0]      frame_length,
    output logic            checksum_ok,
    output logic            address_ok,
    output logic            too_long,
    output logic            coding_error,
    output logic            too_short,
    output logic            frame_good,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_index,
    input  wire logic [7:0] cfg_data
);
    import crx_pkg::*;

    logic        accept;
    crx_event_t  ev;
    crx_status_t status;
    crx_result_t result_next;
    crx_result_t result_reg;
    logic        emit;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  own_id_reg;
    logic [7:0]  id_position_reg;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg      <= '0;
            id_position_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_OWN_ID)
            begin
                own_id_reg <= cfg_data;
            end
            if (cfg_index == CFG_ID_POSITION)
            begin
                id_position_reg <= cfg_data;
            end
        end
    end

    crx_decoder #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_decoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .ev      (ev)
    );

    crx_checker #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .ev          (ev),
        .own_id      (own_id_reg),
        .id_position (id_position_reg),
        .status      (status)
    );

    assign emit = ev.take || ev.close;

    always_comb
    begin
        result_next = '0;
        if (ev.close)
        begin
            result_next.kind = KIND_STATUS;
            if (ev.overrun)
            begin
                // An overrun frame reports only the overrun.
                result_next.too_long = 1'b1;
            end
            else
            begin
                result_next.frame_length = status.frame_length;
                result_next.checksum_ok  = status.checksum_ok;
                result_next.address_ok   = status.address_ok;
                result_next.coding_error = ev.code_err;
                result_next.too_short    = status.too_short;
                result_next.frame_good   = status.checksum_ok && status.address_ok &&
                                           !ev.code_err && !status.too_short;
            end
        end
        else
        begin
            result_next.kind      = KIND_DATA;
            result_next.data_byte = ev.value;
        end
    end

    always_comb
    begin
        priority if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = result_reg.kind;
    assign data_byte    = result_reg.data_byte;
    assign frame_length = result_reg.frame_length;
    assign checksum_ok  = result_reg.checksum_ok;
    assign address_ok   = result_reg.address_ok;
    assign too_long     = result_reg.too_long;
    assign coding_error = result_reg.coding_error;
    assign too_short    = result_reg.too_short;
    assign frame_good   = result_reg.frame_good;

    // A frame end always leaves a status word in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        ev.close |=> (out_valid_reg && result_reg.kind == KIND_STATUS))
        else $error("frame end did not produce a status word");

    // One accepted byte never yields both a data word and a status word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ev.take && ev.close))
        else $error("data and status from the same byte");

    // An overrun status carries no length and is never good.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.too_long) |->
            (result_reg.frame_length == 9'd0 && !result_reg.frame_good))
        else $error("overrun status carries other fields");

    // A good frame has passed every check.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.frame_good) |->
            (result_reg.checksum_ok && result_reg.address_ok &&
             !result_reg.too_short && !result_reg.coding_error))
        else $error("frame_good set with a failed check");

    // A waiting result is never overwritten before it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !emit)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire
